// ===== sv/flmq_pkg.sv =====
package flmq_pkg;

  localparam int MSG_W      = 32;  // message port width
  localparam int CNT_W      = 5;   // count, depth and high-water width
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;   // widest register is the depth register

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_DISCARDED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;

  localparam logic [CNT_W-1:0] DEPTH_RESET = 5'd16;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture input item
    logic exec;      // run the operation on the ring
    logic load_out;  // move result into the output register
  } ctl_cmd_t;

endpackage

// ===== sv/fifo_lifo_message_queue.sv =====
// channel | signals                          | dir | notes
// in      | in_valid/in_ready, in_operation, | in  | enqueue, dequeue or clear
//         | in_message_in                    |     |
// out     | out_valid/out_ready, out_status, | out | one result per item
//         | out_message_out, out_queue_count,|     |
//         | out_high_water                   |     |
// cfg     | cfg_we, cfg_index, cfg_data      | in  | write only, no wait
//
// An item goes through three steps: capture, ring access, result load. The
// next item is taken the cycle after its predecessor's result is loaded, so
// none is taken while one is in flight; the registered read of the ring store
// sets this. A stalled output holds the result load until the register frees.
// Reset (rst_n low, synchronous) empties the queue, clears the high-water mark
// and restores the registers; the ring store itself is not cleared.
module fifo_lifo_message_queue #(
  parameter int MAX_DEPTH    = 16,
  parameter int MESSAGE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [flmq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [flmq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [flmq_pkg::OP_W-1:0]           in_operation,
  input  logic [flmq_pkg::MSG_W-1:0]          in_message_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [flmq_pkg::ST_W-1:0]           out_status,
  output logic [flmq_pkg::MSG_W-1:0]          out_message_out,
  output logic [flmq_pkg::CNT_W-1:0]          out_queue_count,
  output logic [flmq_pkg::CNT_W-1:0]          out_high_water
);
  import flmq_pkg::*;

  ctl_cmd_t cmd;

  // sequencer: idle -> ring access -> result load
  flmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // ring store, pointers, counts, config and output register
  flmq_dpath #(
    .MAX_DEPTH    (MAX_DEPTH),
    .MESSAGE_BITS (MESSAGE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_operation    (in_operation),
    .in_message_in   (in_message_in),
    .cmd             (cmd),
    .out_status      (out_status),
    .out_message_out (out_message_out),
    .out_queue_count (out_queue_count),
    .out_high_water  (out_high_water)
  );

`ifndef SYNTHESIS
  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  // a loaded result shows up at the port
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

  // an empty report carries no word and no count
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |->
      (out_queue_count == '0 && out_message_out == '0))
    else $error("empty result with data or count");

  // count never exceeds the ring
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_queue_count) <= MAX_DEPTH))
    else $error("queue count beyond ring depth");
`endif

endmodule

// ===== sv/flmq_ctrl.sv =====
module flmq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output flmq_pkg::ctl_cmd_t cmd
);
  import flmq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/flmq_dpath.sv =====
module flmq_dpath #(
  parameter int MAX_DEPTH    = 16,
  parameter int MESSAGE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [flmq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [flmq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [flmq_pkg::OP_W-1:0]           in_operation,
  input  logic [flmq_pkg::MSG_W-1:0]          in_message_in,
  input  flmq_pkg::ctl_cmd_t                  cmd,
  output logic [flmq_pkg::ST_W-1:0]           out_status,
  output logic [flmq_pkg::MSG_W-1:0]          out_message_out,
  output logic [flmq_pkg::CNT_W-1:0]          out_queue_count,
  output logic [flmq_pkg::CNT_W-1:0]          out_high_water
);
  import flmq_pkg::*;

  // only the low 32 bits of a word ever reach the ports
  localparam int STORE_W = (MESSAGE_BITS < MSG_W) ? MESSAGE_BITS : MSG_W;
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int SUM_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int DEP_CAP = (MAX_DEPTH < 31) ? MAX_DEPTH : 31;
  localparam logic [SUM_W-1:0] DEPTH_C   = SUM_W'(MAX_DEPTH);
  localparam logic [CNT_W-1:0] DEP_CAP_C = CNT_W'(DEP_CAP);

  // slot sum stays below twice the depth: one compare and subtract
  function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(offs);
    if (s >= DEPTH_C) s = s - DEPTH_C;
    return s[IDX_W-1:0];
  endfunction

  logic [STORE_W-1:0] ring_mem [MAX_DEPTH];

  logic               order_r, policy_r;
  logic [CNT_W-1:0]   depth_r;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   peak_r, peak_nxt;
  logic [OP_W-1:0]    op_r;
  logic [STORE_W-1:0] msg_r;
  logic [ST_W-1:0]    res_status_r, res_status_nxt;
  logic               has_msg_r, has_msg_nxt;
  logic [STORE_W-1:0] rd_data_r;

  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [CNT_W-1:0]   eff_depth;
  logic               full;
  logic [IDX_W-1:0]   head_base;
  logic [CNT_W-1:0]   cnt_base;

  logic [ST_W-1:0]    out_status_r;
  logic [MSG_W-1:0]   out_msg_r;
  logic [CNT_W-1:0]   out_count_r, out_hw_r;

  always_comb begin
    if (depth_r == '0) begin
      eff_depth = CNT_W'(1);
    end else if (depth_r > DEP_CAP_C) begin
      eff_depth = DEP_CAP_C;
    end else begin
      eff_depth = depth_r;
    end
  end

  assign full = (count_r >= eff_depth);

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    peak_nxt       = peak_r;
    res_status_nxt = ST_OK;
    has_msg_nxt    = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = head_r;
    rd_addr        = head_r;
    head_base      = head_r;
    cnt_base       = count_r;
    if (cmd.exec) begin
      unique case (op_r)
        OP_ENQ: begin
          if (full && !policy_r) begin
            res_status_nxt = ST_FULL;
          end else begin
            if (full) begin
              head_base      = wrap_slot(head_r, CNT_W'(1));
              cnt_base       = count_r - CNT_W'(1);
              res_status_nxt = ST_DISCARDED;
            end
            wr_en     = 1'b1;
            wr_addr   = wrap_slot(head_base, cnt_base);
            head_nxt  = head_base;
            count_nxt = cnt_base + CNT_W'(1);
            if (count_nxt > peak_r) peak_nxt = count_nxt;
          end
        end
        OP_DEQ: begin
          if (count_r == '0) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            rd_en       = 1'b1;
            has_msg_nxt = 1'b1;
            count_nxt   = count_r - CNT_W'(1);
            if (!order_r) begin
              rd_addr  = head_r;
              head_nxt = wrap_slot(head_r, CNT_W'(1));
            end else begin
              rd_addr = wrap_slot(head_r, count_r - CNT_W'(1));
            end
          end
        end
        OP_CLR: begin
          peak_nxt = '0;
        end
        default: begin
          // unused code: no change
        end
      endcase
    end
  end

  // ring store, single write and single registered read
  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wr_addr] <= msg_r;
    if (rd_en) rd_data_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= 1'b0;
      policy_r <= 1'b0;
      depth_r  <= DEPTH_RESET;
      head_r   <= '0;
      count_r  <= '0;
      peak_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ORDER:  order_r  <= cfg_data[0];
          CFG_POLICY: policy_r <= cfg_data[0];
          CFG_DEPTH:  depth_r  <= cfg_data;
          default: ;
        endcase
      end
      head_r  <= head_nxt;
      count_r <= count_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_operation;
      msg_r <= in_message_in[STORE_W-1:0];
    end
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      has_msg_r    <= has_msg_nxt;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_msg_r    <= has_msg_r ? MSG_W'(rd_data_r) : '0;
      out_count_r  <= count_r;
      out_hw_r     <= peak_r;
    end
  end

  assign out_status      = out_status_r;
  assign out_message_out = out_msg_r;
  assign out_queue_count = out_count_r;
  assign out_high_water  = out_hw_r;

endmodule

// ===== test/fifo_lifo_message_queue_test.sv =====
module fifo_lifo_message_queue_test;
  import flmq_pkg::*;

  localparam int RING_SLOTS = 16;
  localparam int SLOT_W     = $clog2(RING_SLOTS);
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code: block must leave state alone

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [MSG_W-1:0] message;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] high_water;
  } queue_result_t;

  // Scoreboard: mirrors the ring, pointers and registers, and keeps the
  // results still owed by the block in arrival order.
  class queue_tracker;
    logic [MSG_W-1:0]      ring [RING_SLOTS];
    int unsigned           head_slot;
    logic [CNT_W-1:0]      held;
    logic [CNT_W-1:0]      peak;
    logic                  lifo_order;
    logic                  evict_old;
    logic [CFG_DATA_W-1:0] depth_reg;
    queue_result_t         owed_results[$];
    int unsigned           mismatches;

    function new();
      head_slot   = 0;
      held        = '0;
      peak        = '0;
      lifo_order  = 1'b0;
      evict_old   = 1'b0;
      depth_reg   = DEPTH_RESET;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ORDER:  lifo_order  = val[0];
        CFG_POLICY: evict_old   = val[0];
        CFG_DEPTH:  depth_reg   = val;
        default: ;
      endcase
    endfunction

    function void take_item(logic [OP_W-1:0] op, logic [MSG_W-1:0] word);
      queue_result_t    r;
      logic [CNT_W-1:0] limit;
      r = '0;
      r.status = ST_OK;
      // zero behaves as one, anything past the ring size as the ring size
      limit = (depth_reg == '0) ? CNT_W'(1) :
              (depth_reg > CNT_W'(RING_SLOTS)) ? CNT_W'(RING_SLOTS) : depth_reg;
      case (op)
        OP_ENQ: begin
          if (held >= limit && !evict_old) begin
            r.status = ST_FULL;
          end else begin
            if (held >= limit) begin
              head_slot = (head_slot + 1) % RING_SLOTS;
              held      = held - CNT_W'(1);
              r.status  = ST_DISCARDED;
            end
            ring[SLOT_W'((head_slot + int'(held)) % RING_SLOTS)] = word;
            held = held + CNT_W'(1);
            if (held > peak) peak = held;
          end
        end
        OP_DEQ: begin
          if (held == '0) begin
            r.status = ST_EMPTY;
          end else if (!lifo_order) begin
            r.message = ring[SLOT_W'(head_slot)];
            head_slot = (head_slot + 1) % RING_SLOTS;
            held      = held - CNT_W'(1);
          end else begin
            r.message = ring[SLOT_W'((head_slot + int'(held) - 1) % RING_SLOTS)];
            held      = held - CNT_W'(1);
          end
        end
        OP_CLR: peak = '0;
        default: ;
      endcase
      r.count      = held;
      r.high_water = peak;
      owed_results.push_back(r);
    endfunction

    function void report(string field, logic [MSG_W-1:0] exp, logic [MSG_W-1:0] act);
      $display("%0t: %s expected %0h got %0h", $time, field, exp, act);
      mismatches++;
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t exp;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none got %h", $time, got);
        mismatches++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.status !== exp.status)
        report("status", MSG_W'(exp.status), MSG_W'(got.status));
      if (got.message !== exp.message)
        report("message_out", exp.message, got.message);
      if (got.count !== exp.count)
        report("queue_count", MSG_W'(exp.count), MSG_W'(got.count));
      if (got.high_water !== exp.high_water)
        report("high_water", MSG_W'(exp.high_water), MSG_W'(got.high_water));
    endfunction
  endclass

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_ORDER;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_operation  = OP_ENQ;
  logic [MSG_W-1:0]      in_message_in = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [ST_W-1:0]       out_status;
  logic [MSG_W-1:0]      out_message_out;
  logic [CNT_W-1:0]      out_queue_count;
  logic [CNT_W-1:0]      out_high_water;

  queue_tracker tracker;

  // idle / stall odds in percent, owned by the main sequence
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // long receiver hold-off: main bumps the request count, receiver serves it
  int unsigned hold_requests  = 0;
  int unsigned holds_served   = 0;
  int unsigned hold_left      = 0;

  always #2 clk = ~clk;

  fifo_lifo_message_queue i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_message_in   (in_message_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_message_out (out_message_out),
    .out_queue_count (out_queue_count),
    .out_high_water  (out_high_water)
  );

  // Receiver: random stalls, plus a hold-off on request so the block backs up
  // and has to drop in_ready.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = 80;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: sample both handshakes at the edge, before any NBA update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_item(in_operation, in_message_in);
      if (out_valid && out_ready)
        tracker.check_result({out_status, out_message_out, out_queue_count, out_high_water});
    end
  end

  // Offer one item and return at the edge that takes it. in_valid is left
  // high so a back-to-back item needs no second assignment in the same step.
  task automatic send_item(logic [OP_W-1:0] op, logic [MSG_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_message_in <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender pauses until every owed result is back. It waits for an edge first,
  // so the monitor has logged the last accepted item before the count is read.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic reconfigure(logic order, logic policy, logic [CFG_DATA_W-1:0] depth);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ORDER;
    cfg_data  <= CFG_DATA_W'(order);
    @(posedge clk);
    cfg_index <= CFG_POLICY;
    cfg_data  <= CFG_DATA_W'(policy);
    @(posedge clk);
    cfg_index <= CFG_DEPTH;
    cfg_data  <= depth;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(CFG_ORDER, CFG_DATA_W'(order));
    tracker.write_reg(CFG_POLICY, CFG_DATA_W'(policy));
    tracker.write_reg(CFG_DEPTH, depth);
  endtask

  // Mostly enqueues and dequeues in a phase-dependent balance, with a
  // sprinkling of clears and the spare code.
  function automatic logic [OP_W-1:0] pick_op(int unsigned enq_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return OP_SPARE;
    if (r < 9) return OP_CLR;
    if (r < 9 + enq_pct) return OP_ENQ;
    return OP_DEQ;
  endfunction

  initial begin : main_seq
    logic [CFG_DATA_W-1:0] depth_plan [8];
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings (FIFO, drop newest, depth 16), word extremes,
    // clear, spare code and dequeue from empty.
    send_item(OP_ENQ, 32'h0000_0000);
    send_item(OP_ENQ, 32'hFFFF_FFFF);
    send_item(OP_ENQ, 32'hA5A5_A5A5);
    send_item(OP_DEQ, 32'hFFFF_FFFF);
    send_item(OP_CLR, 32'h1234_5678);
    send_item(OP_SPARE, 32'hDEAD_BEEF);
    send_item(OP_ENQ, 32'h5A5A_5A5A);
    repeat (4) send_item(OP_DEQ, 32'h0);

    // depth 0 acts as one slot; LIFO, newest dropped when full
    reconfigure(1'b1, 1'b0, 5'd0);
    send_item(OP_ENQ, 32'h1234_5678);
    send_item(OP_ENQ, 32'h8765_4321);
    send_item(OP_DEQ, 32'h0);
    send_item(OP_DEQ, 32'h0);

    // depth 2 with oldest discarded on overflow
    reconfigure(1'b1, 1'b1, 5'd2);
    send_item(OP_ENQ, 32'h0000_0001);
    send_item(OP_ENQ, 32'h0000_0002);
    send_item(OP_ENQ, 32'h0000_0003);
    send_item(OP_DEQ, 32'h0);

    // fill to five, then lower the depth under the count: drop-oldest keeps
    // the count, drop-newest refuses; depth above the ring size acts as 16
    reconfigure(1'b0, 1'b1, 5'd16);
    repeat (4) send_item(OP_ENQ, $urandom);
    reconfigure(1'b0, 1'b1, 5'd3);
    send_item(OP_ENQ, 32'hCAFE_F00D);
    reconfigure(1'b0, 1'b0, 5'd3);
    send_item(OP_ENQ, 32'hFEED_FACE);
    reconfigure(1'b0, 1'b0, 5'd31);
    send_item(OP_ENQ, 32'h8000_0001);

    // Random phases: settings and handshake pressure change each phase.
    depth_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd2, 5'd16};
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) depth_plan[3'(phase)] = CFG_DATA_W'($urandom_range(0, 31));
      reconfigure(phase[0], phase[1], depth_plan[3'(phase)]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (phase == 4) begin
        // back the block up: receiver holds off while items keep coming
        send_idle_pct = 0;
        hold_requests = hold_requests + 1;
        repeat (30) send_item(OP_ENQ, $urandom);
      end
      repeat (100) send_item(pick_op(phase[2] ? 40 : 55), $urandom);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
